### sv/lbc_pkg.sv
package lbc_pkg;

  // item kinds carried in the mode field of an input beat
  typedef enum logic [1:0] {
    KIND_TICK       = 2'd0,
    KIND_PIN_CHANGE = 2'd1,
    KIND_SET_MODE   = 2'd2,
    KIND_SET_PERIOD = 2'd3
  } lbc_kind_t;

  localparam int unsigned CH_SLOTS   = 8;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned TIME_W     = 8;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned DELAY_W    = 16;

  localparam int unsigned NUM_LEDS_DEFAULT     = 8;
  localparam int unsigned PERIOD_SHIFT_DEFAULT = 5;

  // channel mode codes
  localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ON     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FLASH  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FREEZE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FOLLOW = 3'd5;

  // highest mode code a set-mode command may carry
  localparam logic [7:0] MODE_CODE_MAX = 8'd5;
  // channel select value that addresses every channel
  localparam logic [7:0] SEL_ALL       = 8'd8;

  localparam logic [DELAY_W-1:0] STEADY_DELAY = 16'd100;
  localparam logic [DELAY_W-1:0] COUNT_MAX    = 16'd8191;

  localparam logic [TIME_W-1:0] TIME_RESET = 8'd8;

  // command fields shared by every channel
  typedef struct packed {
    lbc_kind_t         kind;
    logic [MODE_W-1:0] code;
    logic [TIME_W-1:0] lit;
    logic [TIME_W-1:0] dark;
  } lbc_cmd_t;

endpackage

### sv/lbc_in_if.sv
interface lbc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] led_select;
  logic [7:0] mode_code;
  logic [7:0] lit_period;
  logic [7:0] dark_period;

  modport source (
    output valid, mode, led_select, mode_code, lit_period, dark_period,
    input  ready
  );
  modport sink (
    input  valid, mode, led_select, mode_code, lit_period, dark_period,
    output ready
  );
endinterface

### sv/lbc_out_if.sv
interface lbc_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] led_lit;

  modport source (
    output valid, status, led_lit,
    input  ready
  );
  modport sink (
    input  valid, status, led_lit,
    output ready
  );
endinterface

### sv/lbc_ch.sv
module lbc_ch
  import lbc_pkg::*;
#(
  parameter int unsigned PERIOD_SHIFT = PERIOD_SHIFT_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     go,
  input  logic     hit,
  input  lbc_cmd_t cmd,
  output logic     level,
  output logic     level_next
);

  logic [MODE_W-1:0]  ch_mode;
  logic [MODE_W-1:0]  ch_mode_next;
  logic [TIME_W-1:0]  lit_time;
  logic [TIME_W-1:0]  lit_time_next;
  logic [TIME_W-1:0]  dark_time;
  logic [TIME_W-1:0]  dark_time_next;
  logic [COUNT_W-1:0] countdown;
  logic [COUNT_W-1:0] countdown_next;
  logic [DELAY_W-1:0] delay;

  always_comb begin
    ch_mode_next   = ch_mode;
    lit_time_next  = lit_time;
    dark_time_next = dark_time;
    countdown_next = countdown;
    level_next     = level;
    delay          = STEADY_DELAY;
    case (cmd.kind)
      KIND_TICK: begin
        if (countdown <= COUNT_W'(1)) begin
          unique case (ch_mode)
            MODE_OFF: level_next = 1'b0;
            MODE_ON:  level_next = 1'b1;
            MODE_FLASH: begin
              level_next = ~level;
              // new level lit: wait the lit period, else the dark period
              if (!level) begin
                delay = DELAY_W'(lit_time) << PERIOD_SHIFT;
              end else begin
                delay = DELAY_W'(dark_time) << PERIOD_SHIFT;
              end
            end
            MODE_FREEZE: delay = '0;
            default: ;
          endcase
          countdown_next = (delay > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(delay);
        end else begin
          countdown_next = countdown - COUNT_W'(1);
        end
      end
      KIND_PIN_CHANGE: begin
        if (ch_mode == MODE_FOLLOW) begin
          level_next = ~level;
        end
      end
      KIND_SET_MODE: begin
        if (hit) begin
          ch_mode_next = cmd.code;
        end
      end
      KIND_SET_PERIOD: begin
        if (hit) begin
          lit_time_next  = cmd.lit;
          dark_time_next = cmd.dark;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_mode   <= MODE_FLASH;
      lit_time  <= TIME_RESET;
      dark_time <= TIME_RESET;
      countdown <= '0;
      level     <= 1'b0;
    end else if (go) begin
      ch_mode   <= ch_mode_next;
      lit_time  <= lit_time_next;
      dark_time <= dark_time_next;
      countdown <= countdown_next;
      level     <= level_next;
    end
  end

endmodule

### sv/led_blink_channel_controller.sv
// channel  direction  beat contents
// cmd      in         mode, led_select, mode_code, lit_period, dark_period
// res      out        status, led_lit
//
// one beat per cycle while res is not stalled: a beat is taken into the input register,
// and from there every channel updates and the result register loads.
// res turns valid when the beat moves from the input register into the result register.
// rst is synchronous: all channels flash, periods 8, countdowns 0, leds dark.
// a stall on res holds the result register; cmd keeps taking beats until
// the input register is also full.
module led_blink_channel_controller
  import lbc_pkg::*;
#(
  parameter int unsigned NUM_LEDS     = NUM_LEDS_DEFAULT,
  parameter int unsigned PERIOD_SHIFT = PERIOD_SHIFT_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  lbc_in_if.sink    cmd,
  lbc_out_if.source res
);

  // input register
  logic       in_valid;
  logic [1:0] in_mode;
  logic [7:0] in_sel;
  logic [7:0] in_code;
  logic [7:0] in_lit;
  logic [7:0] in_dark;

  logic       out_free;
  logic       go;
  logic       is_cmd;
  logic       reject;
  lbc_cmd_t   ch_cmd;
  logic [CH_SLOTS-1:0] level_vec;
  logic [CH_SLOTS-1:0] level_next_vec;

  // result register
  logic       out_valid;
  logic       out_status;
  logic [7:0] out_lit;

  assign out_free  = !out_valid || res.ready;
  assign go        = in_valid && out_free;
  assign cmd.ready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      in_valid <= 1'b1;
    end else if (go) begin
      in_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_mode <= cmd.mode;
      in_sel  <= cmd.led_select;
      in_code <= cmd.mode_code;
      in_lit  <= cmd.lit_period;
      in_dark <= cmd.dark_period;
    end
  end

  // commands are the set-mode and set-period kinds; ticks and pin changes
  // never reject
  assign is_cmd = (lbc_kind_t'(in_mode) == KIND_SET_MODE) ||
                  (lbc_kind_t'(in_mode) == KIND_SET_PERIOD);
  assign reject = is_cmd && ((in_sel > SEL_ALL) ||
                  ((lbc_kind_t'(in_mode) == KIND_SET_MODE) && (in_code > MODE_CODE_MAX)));

  assign ch_cmd.kind = lbc_kind_t'(in_mode);
  assign ch_cmd.code = in_code[MODE_W-1:0];
  assign ch_cmd.lit  = in_lit;
  assign ch_cmd.dark = in_dark;

  // one slice per present channel; absent slots read dark
  for (genvar i = 0; i < CH_SLOTS; i++) begin : g_ch
    if (i < NUM_LEDS) begin : g_on
      logic hit;
      assign hit = !reject && ((in_sel == SEL_ALL) || (in_sel == 8'(i)));
      lbc_ch #(
        .PERIOD_SHIFT(PERIOD_SHIFT)
      ) u_ch (
        .clk       (clk),
        .rst       (rst),
        .go        (go),
        .hit       (hit),
        .cmd       (ch_cmd),
        .level     (level_vec[i]),
        .level_next(level_next_vec[i])
      );
    end else begin : g_off
      assign level_vec[i]      = 1'b0;
      assign level_next_vec[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_status <= reject;
      out_lit    <= 8'(level_next_vec);
    end
  end

  assign res.valid   = out_valid;
  assign res.status  = out_status;
  assign res.led_lit = out_lit;

`ifndef SYNTHESIS
  // a command never moves an led level
  a_cmd_keeps_levels: assert property (@(posedge clk) disable iff (rst)
    go && is_cmd |=> level_vec == $past(level_vec))
    else $error("command changed an led level");

  // only a full, stalled pipeline refuses a beat
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> in_valid && out_valid && !res.ready)
    else $error("cmd stalled with room in the pipeline");

  // the result mirrors the channel levels after the beat
  a_result_matches_levels: assert property (@(posedge clk) disable iff (rst)
    go |=> res.valid && res.led_lit == 8'(level_vec))
    else $error("result does not match channel levels");

  // absent channels stay dark
  a_absent_dark: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.led_lit >> NUM_LEDS) == 8'd0)
    else $error("absent channel shows lit");
`endif

endmodule
